@@ rtl/rrs_pkg.sv @@
package rrs_pkg;

    localparam int ACC_W_DEF    = 32;
    localparam int ADDEND_W_DEF = 16;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

endpackage

@@ rtl/rational_running_sum.sv @@
// rational_running_sum: running sum of signed fractions n/d.
// Slave channel: s_axis_tdata carries numerator (low) and denominator,
// s_axis_tlast marks the final fraction of a run. A result word appears on
// the master channel only for the last fraction: reduced numerator,
// positive denominator and status (0 ok, 1 overflow, 2 zero denominator).
// Each fraction passes the back end in order: four arithmetic steps, one
// gcd load, the binary gcd steps, two restoring divisions, one update step
// and one idle step to take the next fraction. The gcd steps are skipped
// when a term is zero. The back end works on one fraction at a time and
// takes no new fraction before the last one is through its sequencer.
// A two-word queue in front takes fractions while the back end works and
// while a result waits; when the receiver stalls, the result word holds
// and the back end stops, then the queue fills and s_axis_tready drops.
// Reset (synchronous, active low) empties the queue and sets the sum to 0/1.
module rational_running_sum
    import rrs_pkg::*;
#(
    parameter int ACC_WIDTH    = ACC_W_DEF,
    parameter int ADDEND_WIDTH = ADDEND_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // addend_numerator, addend_denominator
    input  logic [2*ADDEND_WIDTH-1:0]      s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sum_numerator[31:0], sum_denominator[62:32], sum_status[64:63], zero pad
    output logic [71:0]                    m_axis_tdata
);
    logic                    q_valid, q_ready, q_last;
    logic [ADDEND_WIDTH-1:0] q_num, q_den;
    logic [31:0]             sum_num;
    logic [30:0]             sum_den;
    logic [1:0]              status;

    rrs_front #(.ADDEND_WIDTH(ADDEND_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_num   (s_axis_tdata[ADDEND_WIDTH-1:0]),
        .i_den   (s_axis_tdata[2*ADDEND_WIDTH-1:ADDEND_WIDTH]),
        .i_last  (s_axis_tlast),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_num   (q_num),
        .o_den   (q_den),
        .o_last  (q_last)
    );

    rrs_back #(.ACC_WIDTH(ACC_WIDTH), .ADDEND_WIDTH(ADDEND_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_num     (q_num),
        .i_den     (q_den),
        .i_last    (q_last),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_sum_num (sum_num),
        .o_sum_den (sum_den),
        .o_status  (status)
    );

    // pack the result word, zero fill to whole bytes
    assign m_axis_tdata = {7'd0, status, sum_den, sum_num};
endmodule

@@ rtl/rrs_front.sv @@
// Two-entry queue towards the arithmetic engine.
module rrs_front
    import rrs_pkg::*;
#(
    parameter int ADDEND_WIDTH = ADDEND_W_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ADDEND_WIDTH-1:0] i_num,
    input  logic [ADDEND_WIDTH-1:0] i_den,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ADDEND_WIDTH-1:0] o_num,
    output logic [ADDEND_WIDTH-1:0] o_den,
    output logic                    o_last
);
    localparam int EW = 2 * ADDEND_WIDTH + 1;

    logic [EW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign {o_last, o_den, o_num} = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= {i_last, i_den, i_num};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/rrs_back.sv @@
// Sequencer: cross-multiply, normalise, binary gcd, restoring divide.
module rrs_back
    import rrs_pkg::*;
#(
    parameter int ACC_WIDTH    = ACC_W_DEF,
    parameter int ADDEND_WIDTH = ADDEND_W_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ADDEND_WIDTH-1:0] i_num,
    input  logic [ADDEND_WIDTH-1:0] i_den,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [31:0]             o_sum_num,
    output logic [30:0]             o_sum_den,
    output logic [1:0]              o_status
);
    localparam int AW = ACC_WIDTH;
    localparam int PW = AW + ADDEND_WIDTH;
    localparam int CW = $clog2(AW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUM, S_NORM, S_GCD, S_DIVN, S_DIVD, S_DONE, S_OUT
    } t_state;

    t_state                 r_st;
    logic signed [AW-1:0]   r_an, r_ad;
    logic [1:0]             r_stat;
    logic signed [ADDEND_WIDTH-1:0] r_n, r_d;
    logic                   r_last, r_ovf;
    logic signed [PW-1:0]   r_p;
    logic signed [AW-1:0]   r_p1, r_num, r_den;
    logic [AW-1:0]          r_ga, r_gb, r_g;
    logic [CW-1:0]          r_k;
    logic [AW-1:0]          r_rem, r_dvd;
    logic [CW-1:0]          r_cnt;
    logic [31:0]            r_on;
    logic [30:0]            r_od;
    logic [1:0]             r_os;

    logic signed [PW-1:0]   prod;
    logic signed [AW:0]     sum_x;
    logic [AW:0]            trial;
    logic [AW-1:0]          mag_num, mag_den;
    logic signed [AW-1:0]   amin;

    assign amin    = {1'b1, {(AW-1){1'b0}}};
    assign mag_num = r_num[AW-1] ? AW'(-r_num) : AW'(r_num);
    assign mag_den = r_den[AW-1] ? AW'(-r_den) : AW'(r_den);
    assign sum_x   = {r_p1[AW-1], r_p1} + {r_p[AW-1], r_p[AW-1:0]};
    assign trial   = {r_rem, r_dvd[AW-1]} - {1'b0, r_g};

    // one shared multiplier, operands picked by the step
    always_comb begin
        case (r_st)
            S_MUL1:  prod = r_an * r_d;
            S_MUL2:  prod = r_ad * r_n;
            default: prod = r_ad * r_d;
        endcase
    end

    // product fits when sign extension of the low AW bits reproduces it
    function automatic logic fits(input logic signed [PW-1:0] p);
        fits = (p == PW'($signed(p[AW-1:0])));
    endfunction

    assign o_ready   = (r_st == S_IDLE) && i_valid;
    assign o_valid   = (r_st == S_OUT);
    assign o_sum_num = r_on;
    assign o_sum_den = r_od;
    assign o_status  = r_os;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_an   <= '0;
            r_ad   <= AW'(1);
            r_stat <= ST_OK;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_n    <= $signed(i_num);
                    r_d    <= $signed(i_den);
                    r_last <= i_last;
                    r_ovf  <= 1'b0;
                    r_st   <= S_MUL1;
                end
                S_MUL1: begin
                    r_p  <= prod;
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    r_p1  <= r_p[AW-1:0];
                    r_ovf <= r_ovf | ~fits(r_p);
                    r_p   <= prod;
                    r_st  <= S_SUM;
                end
                S_SUM: begin
                    r_num <= sum_x[AW-1:0];
                    r_ovf <= r_ovf | ~fits(r_p) | (sum_x[AW] != sum_x[AW-1]) | ~fits(prod);
                    r_den <= prod[AW-1:0];
                    r_st  <= S_NORM;
                end
                S_NORM: begin
                    if (r_den[AW-1]) begin
                        if (r_den == amin || r_num == amin) r_ovf <= 1'b1;
                        r_den <= -r_den;
                        r_num <= -r_num;
                    end
                    r_st <= S_GCD;
                    r_cnt <= '0;
                end
                S_GCD: begin
                    // binary gcd: strip common twos, drop other twos, then halve differences
                    if (r_cnt == '0) begin
                        r_ga  <= mag_num;
                        r_gb  <= mag_den;
                        r_k   <= '0;
                        r_cnt <= CW'(1);
                        if (r_num == '0 || r_den == '0) begin
                            r_g  <= AW'(1);
                            r_st <= S_DIVN;
                            r_cnt <= '0;
                        end
                    end else if (r_ga == r_gb) begin
                        r_g   <= r_ga << r_k;
                        r_st  <= S_DIVN;
                        r_cnt <= '0;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + CW'(1);
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= (r_ga - r_gb) >> 1;
                    end else begin
                        r_gb <= (r_gb - r_ga) >> 1;
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (r_cnt == '0) begin
                        r_dvd <= (r_st == S_DIVN) ? mag_num : mag_den;
                        r_rem <= '0;
                        r_cnt <= CW'(1);
                    end else begin
                        r_dvd <= {r_dvd[AW-2:0], ~trial[AW]};
                        r_rem <= trial[AW] ? {r_rem[AW-2:0], r_dvd[AW-1]} : trial[AW-1:0];
                        if (r_cnt == CW'(AW)) begin
                            r_cnt <= '0;
                            if (r_st == S_DIVN) begin
                                r_num <= r_num[AW-1] ? -$signed({r_dvd[AW-2:0], ~trial[AW]})
                                                     : $signed({r_dvd[AW-2:0], ~trial[AW]});
                                r_st  <= S_DIVD;
                            end else begin
                                r_den <= r_den[AW-1] ? -$signed({r_dvd[AW-2:0], ~trial[AW]})
                                                     : $signed({r_dvd[AW-2:0], ~trial[AW]});
                                r_st  <= S_DONE;
                            end
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                S_DONE: begin
                    r_an <= r_num;
                    r_ad <= r_den;
                    if (r_d == '0) r_stat <= ST_ZDEN;
                    else if (r_ovf && r_stat == ST_OK) r_stat <= ST_OVF;
                    r_st <= S_IDLE;
                    if (r_last) begin
                        r_on <= 32'($signed(r_num));
                        r_od <= 31'($unsigned(r_den));
                        r_os <= (r_d == '0) ? ST_ZDEN
                              : (r_ovf && r_stat == ST_OK) ? ST_OVF : r_stat;
                        r_an   <= '0;
                        r_ad   <= AW'(1);
                        r_stat <= ST_OK;
                        r_st   <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
